>>> rtl/sfs_pkg.sv
package sfs_pkg;

	// Field and register widths
	localparam int TIME_W     = 48;
	localparam int DELTA_W    = 24;
	localparam int FRAME_W    = 12;
	localparam int PERIOD_W   = 32;
	localparam int MODE_W     = 3;
	localparam int QUO_W      = 16;
	localparam int MODDIV_W   = FRAME_W + 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Divider pass lengths
	localparam int DIV_STEPS = TIME_W;
	localparam int MOD_STEPS = QUO_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PLAY_MODE    = 2'd2;

	// Play modes
	localparam logic [MODE_W-1:0] MODE_NORMAL    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_REVERSE   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_LOOP      = 3'd2;
	localparam logic [MODE_W-1:0] MODE_LOOP_REV  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_PING_PONG = 3'd4;

	// Controller to datapath commands
	typedef struct packed {
		logic acc;        // add delta into the accumulator
		logic load_main;  // load elapsed / period division
		logic load_mod;   // load quotient / frame modulus division
		logic step;       // one restoring division step
		logic frame_zero; // single frame: force frame 0
		logic map;        // map quotient or remainder to frame
		logic out_load;   // move current frame into output register
	} sfs_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic enabled;  // frame count and period both nonzero
		logic single;   // exactly one frame
		logic need_mod; // mode uses a modulo of the quotient
	} sfs_stat_t;

endpackage

>>> rtl/sfs_in_if.sv
interface sfs_in_if;
	import sfs_pkg::*;

	logic               valid;
	logic               ready;
	logic [DELTA_W-1:0] time_delta;

	modport source (output valid, output time_delta, input ready);
	modport sink (input valid, input time_delta, output ready);
endinterface

>>> rtl/sfs_out_if.sv
interface sfs_out_if;
	import sfs_pkg::*;

	logic               valid;
	logic               ready;
	logic [FRAME_W-1:0] frame_sel;

	modport source (output valid, output frame_sel, input ready);
	modport sink (input valid, input frame_sel, output ready);
endinterface

>>> rtl/sfs_cfg_if.sv
interface sfs_cfg_if;
	import sfs_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/sprite_frame_sequencer.sv
// Flow: an input beat is taken in idle; a disabled update or a single frame goes straight
// to the output; otherwise the shared restoring divider runs 48 steps for the quotient,
// and loop, loop-reverse and ping-pong modes add 16 steps for the modulo before mapping.
// One item in flight: the next input beat is taken once the result is loaded into the
// output register, and that load waits while an earlier output beat is still held.
// Reset (arst_n low): configuration registers, accumulator and frame clear to zero, output idle.
module sprite_frame_sequencer (
	input logic   clk,
	input logic   arst_n,
	sfs_cfg_if.sink   cfg,
	sfs_in_if.sink    item,
	sfs_out_if.source result
);
	import sfs_pkg::*;

	sfs_cmd_t  cmd;
	sfs_stat_t stat;

	// Register writes are taken at any time
	assign cfg.ready = 1'b1;

	sfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sfs_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg.valid),
		.cfg_idx     (cfg.index),
		.cfg_data    (cfg.data),
		.time_delta  (item.time_delta),
		.cmd         (cmd),
		.stat        (stat),
		.frame_sel   (result.frame_sel)
	);
endmodule

>>> rtl/sfs_ctrl.sv
module sfs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  sfs_pkg::sfs_stat_t stat,
	output sfs_pkg::sfs_cmd_t  cmd
);
	import sfs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_DIV,
		ST_MOD_LOAD,
		ST_MOD,
		ST_MAP,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] cnt_q;
	logic              out_valid_q;
	logic              out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// Decode commands from the current state
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:     cmd.acc = in_valid;
			ST_DECIDE: begin
				cmd.frame_zero = stat.enabled && stat.single;
				cmd.load_main  = stat.enabled && !stat.single;
			end
			ST_DIV:      cmd.step = 1'b1;
			ST_MOD_LOAD: cmd.load_mod = 1'b1;
			ST_MOD:      cmd.step = 1'b1;
			ST_MAP:      cmd.map = 1'b1;
			ST_DONE:     cmd.out_load = out_free;
			default:     cmd = '0;
		endcase
	end

	// Sequence one item and hold the output beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (stat.enabled && !stat.single) begin
						cnt_q   <= STEP_W'(DIV_STEPS - 1);
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0)
						state_q <= stat.need_mod ? ST_MOD_LOAD : ST_MAP;
				end
				ST_MOD_LOAD: begin
					cnt_q   <= STEP_W'(MOD_STEPS - 1);
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0)
						state_q <= ST_MAP;
				end
				ST_MAP: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/sfs_datapath.sv
module sfs_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sfs_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [sfs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [sfs_pkg::DELTA_W-1:0]    time_delta,
	input  sfs_pkg::sfs_cmd_t              cmd,
	output sfs_pkg::sfs_stat_t             stat,
	output logic [sfs_pkg::FRAME_W-1:0]    frame_sel
);
	import sfs_pkg::*;

	logic [FRAME_W-1:0]  frame_count_q;
	logic [PERIOD_W-1:0] frame_period_q;
	logic [MODE_W-1:0]   play_mode_q;

	logic [TIME_W-1:0]   elapsed_q;
	logic [FRAME_W-1:0]  frame_q;
	logic [FRAME_W-1:0]  out_frame_q;

	logic [TIME_W-1:0]   dvd_q;
	logic [PERIOD_W-1:0] dsr_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [QUO_W-1:0]    quo_q;

	logic [TIME_W:0]     sum;
	logic [PERIOD_W:0]   trial;
	logic                fits;
	logic [MODDIV_W-1:0] mod_div;
	logic [FRAME_W-1:0]  last;
	logic [MODDIV_W-1:0] r;
	logic [FRAME_W-1:0]  mapped;

	assign stat.enabled  = (frame_count_q != '0) && (frame_period_q != '0);
	assign stat.single   = (frame_count_q == FRAME_W'(1));
	assign stat.need_mod = (play_mode_q == MODE_LOOP) || (play_mode_q == MODE_LOOP_REV)
		|| (play_mode_q == MODE_PING_PONG);

	assign frame_sel = out_frame_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q  <= '0;
			frame_period_q <= '0;
			play_mode_q    <= MODE_NORMAL;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_FRAME_COUNT:  frame_count_q  <= cfg_data[FRAME_W-1:0];
				CFG_FRAME_PERIOD: frame_period_q <= cfg_data[PERIOD_W-1:0];
				CFG_PLAY_MODE:    play_mode_q    <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// Saturating accumulate
	assign sum = {1'b0, elapsed_q} + {{(TIME_W - DELTA_W + 1){1'b0}}, time_delta};

	// One restoring division step
	assign trial = {rem_q, dvd_q[TIME_W-1]};
	assign fits  = (trial >= {1'b0, dsr_q});

	// Modulus for loop modes; ping-pong cycles over 2n-2
	always_comb begin
		if (play_mode_q == MODE_PING_PONG)
			mod_div = {frame_count_q, 1'b0} - MODDIV_W'(2);
		else
			mod_div = {1'b0, frame_count_q};
	end

	// Map quotient or remainder to a frame
	assign last = frame_count_q - 1'b1;
	assign r    = rem_q[MODDIV_W-1:0];
	always_comb begin
		unique case (play_mode_q)
			MODE_REVERSE:
				mapped = (quo_q >= {{(QUO_W - FRAME_W){1'b0}}, last})
					? '0 : last - quo_q[FRAME_W-1:0];
			MODE_LOOP:     mapped = r[FRAME_W-1:0];
			MODE_LOOP_REV: mapped = last - r[FRAME_W-1:0];
			MODE_PING_PONG: begin
				if (r >= {1'b0, frame_count_q})
					mapped = FRAME_W'(mod_div - r);
				else
					mapped = r[FRAME_W-1:0];
			end
			default:
				mapped = (quo_q < {{(QUO_W - FRAME_W){1'b0}}, last})
					? quo_q[FRAME_W-1:0] : last;
		endcase
	end

	// Time and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			frame_q   <= '0;
		end else begin
			if (cmd.acc)
				elapsed_q <= sum[TIME_W] ? '1 : sum[TIME_W-1:0];
			if (cmd.frame_zero)
				frame_q <= '0;
			else if (cmd.map)
				frame_q <= mapped;
		end
	end

	// Divider registers and output register
	always_ff @(posedge clk) begin
		if (cmd.load_main) begin
			dvd_q <= elapsed_q;
			dsr_q <= frame_period_q;
			rem_q <= '0;
		end else if (cmd.load_mod) begin
			dvd_q <= {quo_q, {(TIME_W - QUO_W){1'b0}}};
			dsr_q <= {{(PERIOD_W - MODDIV_W){1'b0}}, mod_div};
			rem_q <= '0;
		end else if (cmd.step) begin
			dvd_q <= {dvd_q[TIME_W-2:0], 1'b0};
			rem_q <= fits ? PERIOD_W'(trial - {1'b0, dsr_q}) : trial[PERIOD_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
		if (cmd.out_load)
			out_frame_q <= frame_q;
	end
endmodule

>>> bench/tb_sprite_frame_sequencer.sv
module tb_sprite_frame_sequencer;
	import sfs_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_STALL     = 300;
	localparam int SETTLE_CYCLES  = 80;
	localparam int RANDOM_PHASES  = 15;
	localparam int PHASE_ITEMS    = 30;

	// Index two bits wide leaves one slot with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sfs_cfg_if cfg_bus();
	sfs_in_if  delta_bus();
	sfs_out_if frame_bus();

	sprite_frame_sequencer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.item   (delta_bus),
		.result (frame_bus)
	);

	always #1 clk = ~clk;

	// Predictor state and register shadow
	logic [TIME_W-1:0]   acc_time;
	logic [FRAME_W-1:0]  shown_frame;
	logic [FRAME_W-1:0]  frames_n;
	logic [PERIOD_W-1:0] period_q;
	logic [MODE_W-1:0]   mode_q;

	logic [DELTA_W-1:0] pending_deltas[$];
	logic [FRAME_W-1:0] expected_frames[$];

	int   mismatches = 0;
	int   idle_cycles = 0;
	int   idle_odds = 0;
	int   stall_asks = 0;
	int   stall_seen = 0;
	int   rx_hold = 0;
	int   recv_gap = 0;
	int   send_gap = 0;
	logic in_fire = 1'b0;

	task automatic report_mismatch(input string what);
		$display("ERROR at %0t: %s", $time, what);
		mismatches++;
	endtask

	// Map a 16-bit quotient to a frame index under the current play mode
	function automatic logic [FRAME_W-1:0] pick_frame(input logic [QUO_W-1:0] q);
		logic [31:0] n;
		logic [31:0] top_frame;
		logic [31:0] span;
		logic [31:0] f;
		n = {20'd0, frames_n};
		top_frame = n - 1;
		case (mode_q)
			MODE_REVERSE: begin
				f = ({16'd0, q} >= top_frame) ? 32'd0 : top_frame - {16'd0, q};
			end
			MODE_LOOP: begin
				f = {16'd0, q} % n;
			end
			MODE_LOOP_REV: begin
				f = top_frame - ({16'd0, q} % n);
			end
			MODE_PING_PONG: begin
				span = 2 * n - 2;
				f = {16'd0, q} % span;
				if (f >= n)
					f = span - f;
			end
			default: begin
				// clamp at the last frame; undefined modes land here too
				f = ({16'd0, q} < top_frame) ? {16'd0, q} : top_frame;
			end
		endcase
		return f[FRAME_W-1:0];
	endfunction

	// Accumulate one delta and return the frame shown after it
	function automatic logic [FRAME_W-1:0] advance_sequencer(input logic [DELTA_W-1:0] delta);
		logic [TIME_W:0] sum;
		logic [63:0]     quot;
		sum = {1'b0, acc_time} + {{(TIME_W + 1 - DELTA_W){1'b0}}, delta};
		acc_time = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
		if (frames_n != 0 && period_q != 0) begin
			if (frames_n == 1) begin
				shown_frame = '0;
			end else begin
				quot = {16'd0, acc_time} / {32'd0, period_q};
				shown_frame = pick_frame(quot[QUO_W-1:0]);
			end
		end
		return shown_frame;
	endfunction

	// Drive delta beats from the pending queue, with random gaps
	always @(negedge clk) begin : drive_deltas
		logic               offer;
		logic [DELTA_W-1:0] next_delta;
		offer = delta_bus.valid;
		next_delta = delta_bus.time_delta;
		if (delta_bus.valid && in_fire)
			offer = 1'b0;
		if (!offer) begin
			if (send_gap > 0) begin
				send_gap--;
			end else if (pending_deltas.size() > 0) begin
				if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
					send_gap = $urandom_range(0, 10);
				end else begin
					offer = 1'b1;
					next_delta = pending_deltas.pop_front();
				end
			end
		end
		delta_bus.valid <= offer;
		delta_bus.time_delta <= next_delta;
	end

	// Drive result ready: long hold-off on request, else random bursts
	always @(negedge clk) begin : drive_ready
		logic take;
		if (stall_seen != stall_asks) begin
			stall_seen = stall_asks;
			rx_hold = LONG_STALL;
		end
		if (rx_hold > 0) begin
			rx_hold--;
			take = 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			take = 1'b0;
		end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			recv_gap = $urandom_range(0, 10);
			take = 1'b0;
		end else begin
			take = 1'b1;
		end
		frame_bus.ready <= take;
	end

	// Check result beats, predict on delta beats, watch for a hang
	always @(posedge clk) begin : watch_beats
		logic [FRAME_W-1:0] want;
		logic               out_beat;
		logic               in_beat;
		logic               cfg_beat;
		out_beat = arst_n && frame_bus.valid && frame_bus.ready;
		in_beat = arst_n && delta_bus.valid && delta_bus.ready;
		cfg_beat = arst_n && cfg_bus.valid && cfg_bus.ready;
		in_fire <= in_beat;
		if (out_beat) begin
			if (expected_frames.size() == 0) begin
				report_mismatch($sformatf("frame_sel %0d with no beat pending",
					frame_bus.frame_sel));
			end else begin
				want = expected_frames.pop_front();
				if (frame_bus.frame_sel !== want)
					report_mismatch($sformatf("frame_sel %0d, expected %0d",
						frame_bus.frame_sel, want));
			end
		end
		if (in_beat)
			expected_frames.push_back(advance_sequencer(delta_bus.time_delta));
		if (in_beat || out_beat || cfg_beat)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Write one register and mirror it into the shadow on the beat
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= value;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		case (idx)
			CFG_FRAME_COUNT:  frames_n = value[FRAME_W-1:0];
			CFG_FRAME_PERIOD: period_q = value[PERIOD_W-1:0];
			CFG_PLAY_MODE:    mode_q = value[MODE_W-1:0];
			default:          ;
		endcase
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	// Write all three registers, sometimes with junk above the field
	task automatic apply_settings(input logic [FRAME_W-1:0] count, input logic [31:0] period,
		input logic [MODE_W-1:0] mode);
		logic [31:0] junk;
		junk = ($urandom_range(0, 2) == 0) ? $urandom : 32'd0;
		write_reg(CFG_FRAME_COUNT, {junk[31:FRAME_W], count});
		write_reg(CFG_FRAME_PERIOD, period);
		junk = ($urandom_range(0, 2) == 0) ? $urandom : 32'd0;
		write_reg(CFG_PLAY_MODE, {junk[31:MODE_W], mode});
	endtask

	// Hold until every queued delta went and every result came back
	task automatic settle();
		do @(posedge clk);
		while (pending_deltas.size() != 0 || delta_bus.valid || expected_frames.size() != 0);
	endtask

	initial begin : stimulus
		int          m;
		int          ph;
		int          k;
		int          r;
		logic [FRAME_W-1:0] cnt;
		logic [31:0] per;
		logic [MODE_W-1:0] md;
		logic [63:0] reach;

		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		delta_bus.valid = 1'b0;
		delta_bus.time_delta = '0;
		frame_bus.ready = 1'b0;
		acc_time = '0;
		shown_frame = '0;
		frames_n = '0;
		period_q = '0;
		mode_q = MODE_NORMAL;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: update disabled, frame held at zero
		@(posedge clk);
		pending_deltas.push_back(24'd0);
		pending_deltas.push_back(24'hFFFFFF);
		settle();

		// Unused register slot must change nothing
		write_reg(CFG_UNUSED, 32'hFFFF_FFFF);

		// Single frame always shows frame zero
		apply_settings(12'd1, 32'hFFFF_FFFF, MODE_PING_PONG);
		@(posedge clk);
		pending_deltas.push_back(24'd1);
		pending_deltas.push_back(24'h800000);
		settle();

		// Largest frame count, one-tick period: quotient wraps at 16 bits
		apply_settings(12'd4095, 32'd1, MODE_NORMAL);
		@(posedge clk);
		pending_deltas.push_back(24'd0);
		pending_deltas.push_back(24'd1);
		settle();

		// Every play mode, undefined ones included
		for (m = 0; m < 8; m++) begin
			apply_settings(12'd5, 32'h10000, m[MODE_W-1:0]);
			@(posedge clk);
			pending_deltas.push_back(24'h18000);
			pending_deltas.push_back(24'h30000);
			settle();
		end

		// Zero period, then zero count: frame held while time still adds up
		apply_settings(12'd5, 32'd0, MODE_LOOP);
		@(posedge clk);
		pending_deltas.push_back(24'hABCDEF);
		settle();
		apply_settings(12'd0, 32'h10000, MODE_LOOP);
		@(posedge clk);
		pending_deltas.push_back(24'd5);
		settle();

		// Random phases, each under fresh settings
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			r = $urandom_range(0, 9);
			case (r)
				0:       cnt = 12'd0;
				1:       cnt = 12'd1;
				2:       cnt = 12'd4095;
				3:       cnt = 12'd2;
				9:       cnt = FRAME_W'($urandom_range(2, 4095));
				default: cnt = FRAME_W'($urandom_range(2, 12));
			endcase
			r = $urandom_range(0, 9);
			case (r)
				0:       per = 32'd0;
				1:       per = 32'd1;
				2:       per = 32'hFFFF_FFFF;
				3:       per = $urandom;
				default: per = $urandom_range(32'h400, 32'h40000);
			endcase
			md = MODE_W'($urandom_range(0, 7));
			apply_settings(cnt, per, md);

			@(posedge clk);
			if (ph >= RANDOM_PHASES - 3 || ph % 3 == 0)
				idle_odds = 0;
			else if (ph % 3 == 1)
				idle_odds = 4;
			else
				idle_odds = 10;
			// hold off the receiver while the sender keeps offering
			if (ph == 5)
				stall_asks++;

			reach = {32'd0, per} * 3;
			if (reach > 64'hFFFFFF || reach == 0)
				reach = 64'hFFFFFF;
			for (k = 0; k < PHASE_ITEMS; k++) begin
				r = $urandom_range(0, 9);
				case (r)
					0:       pending_deltas.push_back(24'd0);
					1:       pending_deltas.push_back(24'hFFFFFF);
					2:       pending_deltas.push_back(DELTA_W'($urandom));
					default: pending_deltas.push_back(DELTA_W'($urandom_range(0, reach[31:0])));
				endcase
			end
			settle();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_frames.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_frames.size()));
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
